// File: rtl/json_string_unescape_utf8_assert.svh
// assertion macros shared by the json string decoder modules
// no dependencies; included by files that carry assertions
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// types, codes and utf-8 packing for the json string decoder
// no dependencies; used by every rtl module of the block
`default_nettype none

package jsu_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
  localparam logic [3:0] ERR_UNTERM     = 4'd2;
  localparam logic [3:0] ERR_CTRL       = 4'd3;
  localparam logic [3:0] ERR_UNTERM_ESC = 4'd4;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd6;
  localparam logic [3:0] ERR_NO_LOW_BS  = 4'd7;
  localparam logic [3:0] ERR_NO_LOW_U   = 4'd8;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd9;
  localparam logic [3:0] ERR_LOW_RANGE  = 4'd10;
  localparam logic [3:0] ERR_LONE_LOW   = 4'd11;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // one group of results caused by one input transaction
  typedef struct packed {
    logic [1:0]      nbytes_m1;
    logic [3:0][7:0] bytes;
    logic [1:0]      kind;
    logic [3:0]      err;
  } item_t;

  function automatic item_t mk_byte(logic [7:0] b);
    item_t it;
    it = '0;
    it.bytes[0] = b;
    it.kind = KIND_BYTE;
    return it;
  endfunction

  function automatic item_t mk_err(logic [3:0] code);
    item_t it;
    it = '0;
    it.kind = KIND_ERR;
    it.err = code;
    return it;
  endfunction

  function automatic item_t mk_done();
    item_t it;
    it = '0;
    it.kind = KIND_DONE;
    return it;
  endfunction

  function automatic item_t utf8_item(logic [20:0] cp);
    item_t it;
    it = '0;
    it.kind = KIND_BYTE;
    if (cp <= 21'h7F) begin
      it.nbytes_m1 = 2'd0;
      it.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      it.nbytes_m1 = 2'd1;
      it.bytes[0] = {3'b110, cp[10:6]};
      it.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      it.nbytes_m1 = 2'd2;
      it.bytes[0] = {4'b1110, cp[15:12]};
      it.bytes[1] = {2'b10, cp[11:6]};
      it.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      it.nbytes_m1 = 2'd3;
      it.bytes[0] = {5'b11110, cp[20:18]};
      it.bytes[1] = {2'b10, cp[17:12]};
      it.bytes[2] = {2'b10, cp[11:6]};
      it.bytes[3] = {2'b10, cp[5:0]};
    end
    return it;
  endfunction

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jsu_front.sv
// front end: decode state machine, one source byte per transaction
// depends on jsu_pkg; pushes one result group per producing transaction
`default_nettype none

module jsu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           eoi_i,
  output jsu_pkg::item_t      item_o,
  output logic                push_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BODY  = 7'b0000010,
    S_ESC   = 7'b0000100,
    S_HEX1  = 7'b0001000,
    S_LOWBS = 7'b0010000,
    S_LOWU  = 7'b0100000,
    S_HEX2  = 7'b1000000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] hacc_r, hacc_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [9:0]  hi_r, hi_nxt;

  logic [4:0]  hd;
  logic [15:0] hval;
  logic        hfull;
  logic [20:0] pair_cp;
  logic        emit;
  jsu_pkg::item_t it;

  assign hd      = jsu_pkg::hex_digit(byte_i);
  assign hval    = {hacc_r[11:0], hd[3:0]};
  assign hfull   = (hcnt_r == 2'd3);
  assign pair_cp = jsu_pkg::SUPP_BASE + {1'b0, hi_r, hval[9:0]};

  always_comb begin
    mode_nxt = mode_r;
    hacc_nxt = hacc_r;
    hcnt_nxt = hcnt_r;
    hi_nxt   = hi_r;
    emit     = 1'b0;
    it       = '0;
    if (eoi_i) begin
      emit     = 1'b1;
      mode_nxt = S_IDLE;
      case (mode_r)
        S_BODY:  it = jsu_pkg::mk_err(jsu_pkg::ERR_UNTERM);
        S_ESC:   it = jsu_pkg::mk_err(jsu_pkg::ERR_UNTERM_ESC);
        S_HEX1:  it = jsu_pkg::mk_err(jsu_pkg::ERR_BAD_HEX);
        S_LOWBS: it = jsu_pkg::mk_err(jsu_pkg::ERR_NO_LOW_BS);
        S_LOWU:  it = jsu_pkg::mk_err(jsu_pkg::ERR_NO_LOW_U);
        S_HEX2:  it = jsu_pkg::mk_err(jsu_pkg::ERR_BAD_LOW);
        default: emit = 1'b0;
      endcase
    end else begin
      case (mode_r)
        S_IDLE: begin
          if (byte_i == jsu_pkg::CH_QUOTE) begin
            mode_nxt = S_BODY;
          end else begin
            emit = 1'b1;
            it   = jsu_pkg::mk_err(jsu_pkg::ERR_NO_QUOTE);
          end
        end
        S_BODY: begin
          if (byte_i == jsu_pkg::CH_QUOTE) begin
            emit     = 1'b1;
            it       = jsu_pkg::mk_done();
            mode_nxt = S_IDLE;
          end else if (byte_i < jsu_pkg::CH_SPACE) begin
            emit     = 1'b1;
            it       = jsu_pkg::mk_err(jsu_pkg::ERR_CTRL);
            mode_nxt = S_IDLE;
          end else if (byte_i == jsu_pkg::CH_BSL) begin
            mode_nxt = S_ESC;
          end else begin
            emit = 1'b1;
            it   = jsu_pkg::mk_byte(byte_i);
          end
        end
        S_ESC: begin
          mode_nxt = S_BODY;
          emit     = 1'b1;
          case (byte_i)
            jsu_pkg::CH_QUOTE: it = jsu_pkg::mk_byte(8'h22);
            jsu_pkg::CH_BSL:   it = jsu_pkg::mk_byte(8'h5C);
            jsu_pkg::CH_SLASH: it = jsu_pkg::mk_byte(8'h2F);
            jsu_pkg::CH_B:     it = jsu_pkg::mk_byte(8'h08);
            jsu_pkg::CH_F:     it = jsu_pkg::mk_byte(8'h0C);
            jsu_pkg::CH_N:     it = jsu_pkg::mk_byte(8'h0A);
            jsu_pkg::CH_R:     it = jsu_pkg::mk_byte(8'h0D);
            jsu_pkg::CH_T:     it = jsu_pkg::mk_byte(8'h09);
            jsu_pkg::CH_U: begin
              emit     = 1'b0;
              hacc_nxt = '0;
              hcnt_nxt = '0;
              mode_nxt = S_HEX1;
            end
            default: begin
              it       = jsu_pkg::mk_err(jsu_pkg::ERR_BAD_ESC);
              mode_nxt = S_IDLE;
            end
          endcase
        end
        S_HEX1: begin
          if (!hd[4]) begin
            emit     = 1'b1;
            it       = jsu_pkg::mk_err(jsu_pkg::ERR_BAD_HEX);
            mode_nxt = S_IDLE;
          end else begin
            hacc_nxt = hval;
            hcnt_nxt = hfull ? 2'd0 : hcnt_r + 2'd1;
            if (hfull) begin
              if (hval >= jsu_pkg::SURR_HI_MIN && hval <= jsu_pkg::SURR_HI_MAX) begin
                hi_nxt   = hval[9:0];
                mode_nxt = S_LOWBS;
              end else if (hval >= jsu_pkg::SURR_LO_MIN &&
                           hval <= jsu_pkg::SURR_LO_MAX) begin
                emit     = 1'b1;
                it       = jsu_pkg::mk_err(jsu_pkg::ERR_LONE_LOW);
                mode_nxt = S_IDLE;
              end else begin
                emit     = 1'b1;
                it       = jsu_pkg::utf8_item({5'd0, hval});
                mode_nxt = S_BODY;
              end
            end
          end
        end
        S_LOWBS: begin
          if (byte_i == jsu_pkg::CH_BSL) begin
            mode_nxt = S_LOWU;
          end else begin
            emit     = 1'b1;
            it       = jsu_pkg::mk_err(jsu_pkg::ERR_NO_LOW_BS);
            mode_nxt = S_IDLE;
          end
        end
        S_LOWU: begin
          if (byte_i == jsu_pkg::CH_U) begin
            hacc_nxt = '0;
            hcnt_nxt = '0;
            mode_nxt = S_HEX2;
          end else begin
            emit     = 1'b1;
            it       = jsu_pkg::mk_err(jsu_pkg::ERR_NO_LOW_U);
            mode_nxt = S_IDLE;
          end
        end
        S_HEX2: begin
          if (!hd[4]) begin
            emit     = 1'b1;
            it       = jsu_pkg::mk_err(jsu_pkg::ERR_BAD_LOW);
            mode_nxt = S_IDLE;
          end else begin
            hacc_nxt = hval;
            hcnt_nxt = hfull ? 2'd0 : hcnt_r + 2'd1;
            if (hfull) begin
              emit = 1'b1;
              if (hval < jsu_pkg::SURR_LO_MIN || hval > jsu_pkg::SURR_LO_MAX) begin
                it       = jsu_pkg::mk_err(jsu_pkg::ERR_LOW_RANGE);
                mode_nxt = S_IDLE;
              end else begin
                it       = jsu_pkg::utf8_item(pair_cp);
                mode_nxt = S_BODY;
              end
            end
          end
        end
        default: mode_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= S_IDLE;
      hacc_r <= '0;
      hcnt_r <= '0;
      hi_r   <= '0;
    end else if (acc_i) begin
      mode_r <= mode_nxt;
      hacc_r <= hacc_nxt;
      hcnt_r <= hcnt_nxt;
      hi_r   <= hi_nxt;
    end
  end

  assign item_o = it;
  assign push_o = acc_i & emit;

endmodule

`default_nettype wire

// File: rtl/jsu_fifo.sv
// short queue of result groups between front and back end
// depends on jsu_pkg for item_t and depth constants
`default_nettype none
`include "json_string_unescape_utf8_assert.svh"

module jsu_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  wire jsu_pkg::item_t push_data_i,
  output logic                full_o,
  output logic                nempty_o,
  input  wire logic           pop_i,
  output jsu_pkg::item_t      pop_data_o
);

  jsu_pkg::item_t                  mem_r [jsu_pkg::FIFO_DEPTH];
  logic [jsu_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [jsu_pkg::FIFO_CW-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full_o     = (count_r == jsu_pkg::FIFO_CW'(jsu_pkg::FIFO_DEPTH));
  assign nempty_o   = (count_r != '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & nempty_o;
  assign pop_data_o = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  `JSU_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= jsu_pkg::FIFO_CW'(jsu_pkg::FIFO_DEPTH), "queue count above depth")
  `JSU_ASSERT_NEXT(a_ptr_gap, clk, rst_n, 1'b1, (wr_ptr_r - rd_ptr_r) == count_r[jsu_pkg::FIFO_AW-1:0], "queue pointers disagree with count")

endmodule

`default_nettype wire

// File: rtl/jsu_back.sv
// back end: walks each queued result group and drives the output register
// depends on jsu_pkg; one result transaction per cycle when not stalled
`default_nettype none
`include "json_string_unescape_utf8_assert.svh"

module jsu_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           nempty_i,
  input  wire jsu_pkg::item_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic [1:0]          out_kind_o,
  output logic [3:0]          out_err_o,
  output logic                out_last_o
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic [1:0] kind_r;
  logic [3:0] err_r;
  logic       last_r;
  logic       load, last_now;

  assign load      = nempty_i & (~valid_r | out_ready_i);
  assign last_now  = (idx_r == head_i.nbytes_m1);
  assign pop_o     = load & last_now;
  assign valid_nxt = load | (valid_r & ~out_ready_i);

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_now ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_i.bytes[idx_r];
      kind_r <= head_i.kind;
      err_r  <= head_i.err;
      last_r <= last_now;
    end
  end

  assign out_valid_o = valid_r;
  assign out_byte_o  = byte_r;
  assign out_kind_o  = kind_r;
  assign out_err_o   = err_r;
  assign out_last_o  = last_r;

  `JSU_ASSERT_NOW(a_marker_last, clk, rst_n, valid_r && kind_r != jsu_pkg::KIND_BYTE, last_r, "done or error result not marked last")
  `JSU_ASSERT_NOW(a_err_code, clk, rst_n, valid_r && kind_r == jsu_pkg::KIND_ERR, err_r != jsu_pkg::ERR_NONE, "error result without code")

endmodule

`default_nettype wire

// File: rtl/json_string_unescape_utf8.sv
// Streaming unescaper for one quoted JSON string literal, UTF-8 output.
// Input channel in_*: one source byte per transaction, in_tdata[7:0] the
// byte, in_tlast set for end of input (byte then ignored). Output channel
// out_*: out_tdata[7:0] decoded byte, out_tdata[11:8] error code,
// out_tuser kind (0 byte, 1 string complete, 2 error), out_tlast marks the
// final result caused by one input transaction.
// Each result group is written into the queue when its input is accepted and
// then loaded into the output register. Throughput: one input per cycle while
// the queue is not full; an input that yields several bytes (a \u escape, up to
// four) sends them one at a time through the single output register in the back end.
// A four-entry queue of result groups sits between decoder and output, so
// input keeps flowing while the receiver stalls until that queue fills;
// in_tready drops only when it is full.
// Reset (rst_n low, synchronous) empties the queue and output register and
// puts the decoder back to waiting for an opening quote.
// depends on jsu_pkg, jsu_front, jsu_fifo, jsu_back
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last
);

  jsu_pkg::item_t push_item, head_item;
  logic           push, full, nempty, pop, in_acc;
  logic [7:0]     o_byte;
  logic [3:0]     o_err;

  assign in_tready = ~full;
  assign in_acc    = in_tvalid & ~full;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_i  (in_acc),
    .byte_i (in_tdata),
    .eoi_i  (in_tlast),
    .item_o (push_item),
    .push_o (push)
  );

  jsu_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (full),
    .nempty_o    (nempty),
    .pop_i       (pop),
    .pop_data_o  (head_item)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .nempty_i    (nempty),
    .head_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_byte_o  (o_byte),
    .out_kind_o  (out_tuser),
    .out_err_o   (o_err),
    .out_last_o  (out_tlast)
  );

  assign out_tdata = {4'd0, o_err, o_byte};

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for json_string_unescape_utf8: a directed table, then random
// strings with injected faults, checked against table results or a predictor in this file
// depends on jsu_pkg and the json_string_unescape_utf8 rtl

module tb;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 480;
  localparam int CALM_TAIL = 60;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_BODY, MODE_ESC, MODE_HEX, MODE_LOW_BSL, MODE_LOW_U, MODE_LOW_HEX
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] err;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       fixed;
    result_t    want;
  } stim_t;

  localparam stim_t DIRECTED [0:26] = '{
    '{8'h00, 1'b1, 1'b0, '0},
    '{"A", 1'b0, 1'b1, '{8'h00, KIND_ERR, ERR_NO_QUOTE, 1'b1}},
    '{CH_QUOTE, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_BYTE, ERR_NONE, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, '0},
    '{CH_U, 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b1, '{8'h00, KIND_BYTE, ERR_NONE, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, '0},
    '{CH_U, 1'b0, 1'b0, '0},
    '{"D", 1'b0, 1'b0, '0},
    '{"B", 1'b0, 1'b0, '0},
    '{"F", 1'b0, 1'b0, '0},
    '{"F", 1'b0, 1'b0, '0},
    '{CH_BSL, 1'b0, 1'b0, '0},
    '{CH_U, 1'b0, 1'b0, '0},
    '{"D", 1'b0, 1'b0, '0},
    '{"F", 1'b0, 1'b0, '0},
    '{"F", 1'b0, 1'b0, '0},
    '{"F", 1'b0, 1'b0, '0},
    '{CH_QUOTE, 1'b0, 1'b1, '{8'h00, KIND_DONE, ERR_NONE, 1'b1}},
    '{CH_QUOTE, 1'b0, 1'b0, '0},
    '{8'h1F, 1'b0, 1'b1, '{8'h00, KIND_ERR, ERR_CTRL, 1'b1}},
    '{CH_QUOTE, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{8'h00, KIND_ERR, ERR_UNTERM, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  stim_t   stim_q[$];
  result_t pending_q[$];
  result_t grp[4];
  int      grp_n;
  int      fail_cnt = 0;
  int      checked_cnt = 0;
  int      accepted_cnt = 0;
  int      done_cnt = 0;
  int      cycle_cnt = 0;
  logic [15:0] err_seen = '0;
  bit      calm = 1'b0;

  mode_t       dec_mode = MODE_IDLE;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_cnt = '0;
  logic [9:0]  high_bits = '0;

  // decoder predictor

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic add_result(logic [7:0] b, logic [1:0] k, logic [3:0] e);
    grp[grp_n] = '{b, k, e, 1'b0};
    grp_n++;
  endtask

  task automatic add_error(logic [3:0] e);
    add_result(8'h00, KIND_ERR, e);
    dec_mode = MODE_IDLE;
  endtask

  task automatic add_code_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(cp[7:0], KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      add_result(8'hC0 | {3'b0, cp[10:6]}, KIND_BYTE, ERR_NONE);
      add_result(8'h80 | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      add_result(8'hE0 | {4'b0, cp[15:12]}, KIND_BYTE, ERR_NONE);
      add_result(8'h80 | {2'b0, cp[11:6]}, KIND_BYTE, ERR_NONE);
      add_result(8'h80 | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else begin
      add_result(8'hF0 | {5'b0, cp[20:18]}, KIND_BYTE, ERR_NONE);
      add_result(8'h80 | {2'b0, cp[17:12]}, KIND_BYTE, ERR_NONE);
      add_result(8'h80 | {2'b0, cp[11:6]}, KIND_BYTE, ERR_NONE);
      add_result(8'h80 | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end
  endtask

  // shifts in one nibble, returns 1 when the fourth digit lands
  function automatic bit shift_digit(int d);
    hex_acc = {hex_acc[11:0], 4'(d)};
    if (hex_cnt == 2'd3) begin
      hex_cnt = 2'd0;
      return 1'b1;
    end
    hex_cnt = hex_cnt + 2'd1;
    return 1'b0;
  endfunction

  task automatic decode_step(logic [7:0] c, logic eoi);
    int d;
    logic [20:0] cp;
    grp_n = 0;
    if (eoi) begin
      case (dec_mode)
        MODE_BODY:    add_error(ERR_UNTERM);
        MODE_ESC:     add_error(ERR_UNTERM_ESC);
        MODE_HEX:     add_error(ERR_BAD_HEX);
        MODE_LOW_BSL: add_error(ERR_NO_LOW_BS);
        MODE_LOW_U:   add_error(ERR_NO_LOW_U);
        MODE_LOW_HEX: add_error(ERR_BAD_LOW);
        default: ;
      endcase
    end else begin
      case (dec_mode)
        MODE_IDLE: begin
          if (c == CH_QUOTE) dec_mode = MODE_BODY;
          else add_error(ERR_NO_QUOTE);
        end
        MODE_BODY: begin
          if (c == CH_QUOTE) begin
            add_result(8'h00, KIND_DONE, ERR_NONE);
            dec_mode = MODE_IDLE;
          end else if (c < CH_SPACE) begin
            add_error(ERR_CTRL);
          end else if (c == CH_BSL) begin
            dec_mode = MODE_ESC;
          end else begin
            add_result(c, KIND_BYTE, ERR_NONE);
          end
        end
        MODE_ESC: begin
          dec_mode = MODE_BODY;
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: add_result(c, KIND_BYTE, ERR_NONE);
            CH_B: add_result(8'h08, KIND_BYTE, ERR_NONE);
            CH_F: add_result(8'h0C, KIND_BYTE, ERR_NONE);
            CH_N: add_result(8'h0A, KIND_BYTE, ERR_NONE);
            CH_R: add_result(8'h0D, KIND_BYTE, ERR_NONE);
            CH_T: add_result(8'h09, KIND_BYTE, ERR_NONE);
            CH_U: begin
              hex_acc = '0;
              hex_cnt = '0;
              dec_mode = MODE_HEX;
            end
            default: add_error(ERR_BAD_ESC);
          endcase
        end
        MODE_HEX: begin
          d = hex_val(c);
          if (d < 0) begin
            add_error(ERR_BAD_HEX);
          end else if (shift_digit(d)) begin
            if (hex_acc >= SURR_HI_MIN && hex_acc <= SURR_HI_MAX) begin
              high_bits = 10'(hex_acc - SURR_HI_MIN);
              dec_mode = MODE_LOW_BSL;
            end else if (hex_acc >= SURR_LO_MIN && hex_acc <= SURR_LO_MAX) begin
              add_error(ERR_LONE_LOW);
            end else begin
              add_code_point({5'b0, hex_acc});
              dec_mode = MODE_BODY;
            end
          end
        end
        MODE_LOW_BSL: begin
          if (c == CH_BSL) dec_mode = MODE_LOW_U;
          else add_error(ERR_NO_LOW_BS);
        end
        MODE_LOW_U: begin
          if (c == CH_U) begin
            hex_acc = '0;
            hex_cnt = '0;
            dec_mode = MODE_LOW_HEX;
          end else begin
            add_error(ERR_NO_LOW_U);
          end
        end
        MODE_LOW_HEX: begin
          d = hex_val(c);
          if (d < 0) begin
            add_error(ERR_BAD_LOW);
          end else if (shift_digit(d)) begin
            if (hex_acc < SURR_LO_MIN || hex_acc > SURR_LO_MAX) begin
              add_error(ERR_LOW_RANGE);
            end else begin
              cp = SUPP_BASE + ({11'b0, high_bits} << 10) + 21'(hex_acc - SURR_LO_MIN);
              add_code_point(cp);
              dec_mode = MODE_BODY;
            end
          end
        end
        default: dec_mode = MODE_IDLE;
      endcase
    end
    if (grp_n > 0) grp[grp_n - 1].last = 1'b1;
  endtask

  // random source text

  task automatic put(logic [7:0] b);
    stim_t s;
    s = '0;
    s.data = b;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic put_end();
    stim_t s;
    s = '0;
    s.data = 8'($urandom_range(0, 255));
    s.eoi = 1'b1;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic put_hex(logic [15:0] v, int ndig);
    logic [3:0] nib;
    for (int k = 3; k > 3 - ndig; k--) begin
      nib = v[k*4 +: 4];
      if (nib < 4'd10) put("0" + 8'(nib));
      else if ($urandom_range(0, 1)) put("a" + 8'(nib - 4'd10));
      else put("A" + 8'(nib - 4'd10));
    end
  endtask

  task automatic put_unicode(logic [15:0] v);
    put(CH_BSL);
    put(CH_U);
    put_hex(v, 4);
  endtask

  task automatic put_high();
    put_unicode(16'($urandom_range(int'(SURR_HI_MIN), int'(SURR_HI_MAX))));
  endtask

  // stray digit run ended by a non-hex byte or by end of input
  task automatic put_broken_hex();
    logic [7:0] b;
    put_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      put_end();
    end else begin
      do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
      put(b);
    end
  endtask

  task automatic put_element();
    logic [7:0] b;
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0, 1: begin
        do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSL);
        put(b);
      end
      2: begin
        put(CH_BSL);
        case ($urandom_range(0, 7))
          0: put(CH_QUOTE);
          1: put(CH_BSL);
          2: put(CH_SLASH);
          3: put(CH_B);
          4: put(CH_F);
          5: put(CH_N);
          6: put(CH_R);
          default: put(CH_T);
        endcase
      end
      3: begin
        case ($urandom_range(0, 4))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          2: v = 16'($urandom_range(16'h800, 16'hD7FF));
          3: v = 16'($urandom_range(16'hE000, 16'hFFFF));
          default: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        put_unicode(v);
      end
      4: begin
        put_high();
        put_unicode(16'($urandom_range(int'(SURR_LO_MIN), int'(SURR_LO_MAX))));
      end
      default: put(8'($urandom_range(32, 126)));
    endcase
  endtask

  task automatic put_fault();
    logic [7:0] b;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: put(8'($urandom_range(0, 31)));
      1: put_end();
      2: begin
        put(CH_BSL);
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        put(b);
      end
      3: begin
        put(CH_BSL);
        put_end();
      end
      4: begin
        put(CH_BSL);
        put(CH_U);
        put_broken_hex();
      end
      5: put_unicode(16'($urandom_range(int'(SURR_LO_MIN), int'(SURR_LO_MAX))));
      6: begin
        put_high();
        if ($urandom_range(0, 3) == 0) begin
          put_end();
        end else if ($urandom_range(0, 2) == 0) begin
          put(CH_QUOTE);
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_BSL);
          put(b);
        end
      end
      7: begin
        put_high();
        put(CH_BSL);
        if ($urandom_range(0, 3) == 0) begin
          put_end();
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_U);
          put(b);
        end
      end
      8: begin
        put_high();
        put(CH_BSL);
        put(CH_U);
        put_broken_hex();
      end
      default: begin
        put_high();
        do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= SURR_LO_MIN && v <= SURR_LO_MAX);
        put_unicode(v);
      end
    endcase
  endtask

  task automatic put_string();
    int nelem;
    int fault_at;
    nelem = $urandom_range(0, 8);
    fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nelem) : -1;
    put(CH_QUOTE);
    for (int k = 0; k <= nelem; k++) begin
      if (k == fault_at) begin
        put_fault();
        return;
      end
      if (k < nelem) put_element();
    end
    put(CH_QUOTE);
  endtask

  // checking

  task automatic report_mismatch(string what, int got, int want);
    fail_cnt++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  always @(posedge clk) begin : predict_in
    stim_t s;
    if (rst_n && in_tvalid && in_tready) begin
      s = stim_q[accepted_cnt];
      accepted_cnt++;
      decode_step(s.data, s.eoi);
      if (s.fixed) begin
        pending_q.insert(pending_q.size(), s.want);
      end else begin
        for (int k = 0; k < grp_n; k++) pending_q.insert(pending_q.size(), grp[k]);
      end
    end
  end

  always @(posedge clk) begin : check_out
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with none pending", int'(out_tdata), 0);
      end else begin
        want = pending_q.pop_front();
        checked_cnt++;
        if (want.kind == KIND_ERR) err_seen[want.err] = 1'b1;
        if (want.kind == KIND_DONE) done_cnt++;
        if (out_tdata[7:0] != want.data) report_mismatch("byte", out_tdata[7:0], want.data);
        if (out_tdata[11:8] != want.err) report_mismatch("error code", out_tdata[11:8], want.err);
        if (out_tdata[15:12] != 4'h0) report_mismatch("tdata pad", out_tdata[15:12], 0);
        if (out_tuser != want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tlast != want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  // receiver side: random stalls, one long hold-off
  initial begin : sink
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && checked_cnt >= 120) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (cycle_cnt < CYCLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  initial begin : main
    int pause_at;
    foreach (DIRECTED[k]) stim_q.insert(stim_q.size(), DIRECTED[k]);
    while (stim_q.size() < $size(DIRECTED) + RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) put(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 11) == 0) put_end();
      put_string();
    end
    pause_at = $size(DIRECTED) + 200;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i >= stim_q.size() - CALM_TAIL) calm = 1'b1;
      if (i == pause_at) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= stim_q[i].data;
      in_tlast <= stim_q[i].eoi;
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("decoded %0d input transactions into %0d checked results, %0d strings closed",
             accepted_cnt, checked_cnt, done_cnt);
    $display("error codes hit (bit n = code n): %b", err_seen);
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: json_string_unescape_utf8.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/tb.sv
